### hdl/oifdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// OSPF interface DR election package
// Shared types and constants for the interface state machine and election.
// ----------------------------------------------------------------------------
package oifdr_pkg;

  localparam int unsigned SlotW = 4;
  localparam int unsigned NbW   = 32 + 8 + 1 + 32 + 32;

  localparam logic [2:0] StDown    = 3'd0;
  localparam logic [2:0] StLoop    = 3'd1;
  localparam logic [2:0] StWaiting = 3'd2;
  localparam logic [2:0] StP2p     = 3'd3;
  localparam logic [2:0] StDrOther = 3'd4;
  localparam logic [2:0] StBackup  = 3'd5;
  localparam logic [2:0] StDr      = 3'd6;

  localparam logic [3:0] EvUp     = 4'd0;
  localparam logic [3:0] EvLoop   = 4'd1;
  localparam logic [3:0] EvDown   = 4'd2;
  localparam logic [3:0] EvUnloop = 4'd3;
  localparam logic [3:0] EvBackup = 4'd4;
  localparam logic [3:0] EvWait   = 4'd5;
  localparam logic [3:0] EvNbChg  = 4'd6;
  localparam logic [3:0] EvHello  = 4'd7;

  localparam logic [2:0] TypeBcast = 3'd0;
  localparam logic [2:0] TypeNbma  = 3'd1;
  localparam logic [2:0] TypeP2p   = 3'd2;
  localparam logic [2:0] TypeP2mp  = 3'd3;
  localparam logic [2:0] TypeVirt  = 3'd4;

  localparam logic [1:0] RegRouterId  = 2'd0;
  localparam logic [1:0] RegPriority  = 2'd1;
  localparam logic [1:0] RegIfType    = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  pri;
    logic        twoway;
    logic [31:0] dr;
    logic [31:0] bdr;
  } nb_entry_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  slot;
    logic        neighbor_present;
    logic [31:0] neighbor_id;
    logic [7:0]  neighbor_priority;
    logic        neighbor_twoway;
    logic [31:0] neighbor_dr;
    logic [31:0] neighbor_bdr;
    logic [3:0]  event_code;
  } req_t;

  typedef struct packed {
    logic [2:0]  iface_state;
    logic [31:0] designated_router;
    logic [31:0] backup_router;
    logic        start_hello_timer;
    logic        start_wait_timer;
    logic        hello_multicast;
    logic [15:0] hello_unicast_mask;
    logic [15:0] neighbor_start_mask;
    logic [15:0] adjacency_check_mask;
    logic        interface_reset;
  } rsp_t;

  function automatic logic beats(input logic [7:0] p, input logic [31:0] id,
                                 input logic [7:0] bp, input logic [31:0] bid);
    beats = (p > bp) || (p == bp && id > bid);
  endfunction

endpackage
`default_nettype wire

### hdl/oifdr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// OSPF interface DR election channel interfaces
// Valid/ready channels carrying a request and a result.
// ----------------------------------------------------------------------------
interface oifdr_req_if import oifdr_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface oifdr_rsp_if import oifdr_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/oifdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module oifdr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                             wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/ospf_interface_fsm_dr_election.sv
`default_nettype none
// ----------------------------------------------------------------------------
// OSPF interface state machine with DR/BDR election
// Interface state, DR and BDR, and a neighbour table held in one RAM.
// ----------------------------------------------------------------------------
// Each request gives one result. Events that need the neighbour table sweep it
// through the RAM read port, one slot a cycle. For a neighbour write or a simple
// event the accepted request moves the machine to the response state, which then
// registers the result. Interface up on NBMA with a non-zero priority, or a hello
// that needs the table, first sweeps the table once. An election takes two sweeps
// per round and one more sweep for the start and adjacency masks, with one round
// or two. A new request is taken in the cycle after the result has been taken.
// Valid bits are flip-flops cleared by reset; the RAM itself needs no clearing
// pass.
module ospf_interface_fsm_dr_election import oifdr_pkg::*; #(
  parameter int unsigned MAX_NEIGHBORS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  oifdr_req_if.sink        req_i,
  oifdr_rsp_if.source      rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int unsigned AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SScan  = 3'd1;
  localparam logic [2:0] SElA   = 3'd2;
  localparam logic [2:0] SElB   = 3'd3;
  localparam logic [2:0] SResp  = 3'd4;
  localparam logic [2:0] SMask  = 3'd5;

  localparam logic [1:0] ScUp    = 2'd0;
  localparam logic [1:0] ScHello = 2'd1;
  localparam logic [1:0] ScAct   = 2'd2;

  logic [31:0] rid_q;
  logic [7:0]  rpri_q;
  logic [2:0]  itype_q;

  logic [2:0]  fsm_q, fsm_d;
  logic [1:0]  scan_q, scan_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        round_q, round_d;
  logic [2:0]  st_q, st_d;
  logic [31:0] dr_q, dr_d, bdr_q, bdr_d;
  logic [MAX_NEIGHBORS-1:0] valid_q, valid_d;
  req_t        req_q, req_d;
  rsp_t        rsp_q, rsp_d;
  logic        rsp_vld_q, rsp_vld_d;

  logic [31:0] cdr_q, cdr_d, cbdr_q, cbdr_d, ebdr_q, ebdr_d, edr_q, edr_d;
  logic [31:0] hi_q, hi_d;
  logic [7:0]  bpri_q, bpri_d, hpri_q, hpri_d, dpri_q, dpri_d;
  logic        bfound_q, bfound_d, dfound_q, dfound_d, ufound_q, ufound_d;
  logic [15:0] uc_q, uc_d, sm_q, sm_d, am_q, am_d;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  nb_entry_t   ram_wdata, ent;
  logic [AW-1:0] rd_idx;

  oifdr_ram #(.Width(NbW), .Depth(MAX_NEIGHBORS)) u_nb_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ent)
  );

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      RegRouterId: prdata = rid_q;
      RegPriority: prdata = {24'd0, rpri_q};
      RegIfType:   prdata = {29'd0, itype_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rid_q   <= 32'd0;
      rpri_q  <= 8'd1;
      itype_q <= TypeBcast;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegRouterId: rid_q   <= pwdata;
        RegPriority: rpri_q  <= pwdata[7:0];
        RegIfType:   itype_q <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready   = (fsm_q == SIdle) && !rsp_vld_q;
  assign rsp_o.valid   = rsp_vld_q;
  assign rsp_o.payload = rsp_q;

  // Slot whose data arrives from the RAM this cycle.
  assign rd_idx = AW'(cnt_q - CW'(1));

  logic        el_cnt, in_rng;
  logic        ent_v, ent_elig;
  logic        el_changed, is_b, is_d, is_o, was_b, was_d, was_o, was_w, drchg;
  logic [31:0] fdr, fbdr, bdr_t;
  logic [7:0]  bpri_t;
  logic        bfound_t;
  logic [15:0] bit_m;

  always_comb begin
    fsm_d = fsm_q; scan_d = scan_q; cnt_d = cnt_q; round_d = round_q;
    st_d = st_q; dr_d = dr_q; bdr_d = bdr_q; valid_d = valid_q;
    req_d = req_q; rsp_d = rsp_q; rsp_vld_d = rsp_vld_q;
    cdr_d = cdr_q; cbdr_d = cbdr_q; ebdr_d = ebdr_q; edr_d = edr_q; hi_d = hi_q;
    bpri_d = bpri_q; hpri_d = hpri_q; dpri_d = dpri_q;
    bfound_d = bfound_q; dfound_d = dfound_q; ufound_d = ufound_q;
    uc_d = uc_q; sm_d = sm_q; am_d = am_q;
    ram_we = 1'b0; ram_waddr = AW'(req_i.payload.slot);
    ram_raddr = AW'(cnt_q);
    ram_wdata = '{id: req_i.payload.neighbor_id, pri: req_i.payload.neighbor_priority,
                  twoway: req_i.payload.neighbor_twoway, dr: req_i.payload.neighbor_dr,
                  bdr: req_i.payload.neighbor_bdr};
    el_cnt = (cnt_q != CW'(0));
    ent_v = el_cnt && valid_q[rd_idx];
    ent_elig = ent_v && ent.twoway && (ent.pri != 8'd0);
    bit_m = 16'd0;
    if (el_cnt) bit_m = 16'(1) << rd_idx;
    in_rng = ({28'd0, req_i.payload.slot} < 32'(MAX_NEIGHBORS));
    fdr = 32'd0; fbdr = 32'd0; bdr_t = bdr_q; bpri_t = bpri_q; bfound_t = bfound_q;
    el_changed = 1'b0; is_b = 1'b0; is_d = 1'b0; is_o = 1'b0;
    was_b = 1'b0; was_d = 1'b0; was_o = 1'b0; was_w = 1'b0; drchg = 1'b0;

    if (rsp_vld_q && rsp_o.ready) rsp_vld_d = 1'b0;

    unique case (fsm_q)
      SIdle: begin
        if (req_i.valid && req_i.ready) begin
          req_d = req_i.payload;
          rsp_d = '0;
          uc_d = '0; sm_d = '0; am_d = '0; ufound_d = 1'b0;
          cnt_d = '0; round_d = 1'b0;
          fsm_d = SResp;
          if (!req_i.payload.mode) begin
            if (in_rng) begin
              ram_we = 1'b1;
              valid_d[AW'(req_i.payload.slot)] = req_i.payload.neighbor_present;
            end
          end else begin
            priority if (st_q == StDown) begin
              if (req_i.payload.event_code == EvUp) begin
                rsp_d.start_hello_timer = 1'b1;
                if (itype_q == TypeP2p || itype_q == TypeP2mp || itype_q == TypeVirt) begin
                  st_d = StP2p;
                end else if (itype_q == TypeBcast || itype_q == TypeNbma) begin
                  if (rpri_q == 8'd0) st_d = StDrOther;
                  else begin
                    st_d = StWaiting;
                    rsp_d.start_wait_timer = 1'b1;
                    if (itype_q == TypeNbma) begin
                      scan_d = ScUp; fsm_d = SScan;
                    end
                  end
                end
              end else if (req_i.payload.event_code == EvLoop) begin
                rsp_d.interface_reset = 1'b1; st_d = StLoop;
              end
            end else if (st_q == StLoop) begin
              if (req_i.payload.event_code == EvDown) begin
                rsp_d.interface_reset = 1'b1; st_d = StDown;
              end else if (req_i.payload.event_code == EvUnloop) st_d = StDown;
            end else begin
              if (req_i.payload.event_code == EvDown) begin
                rsp_d.interface_reset = 1'b1; st_d = StDown;
              end else if (req_i.payload.event_code == EvLoop) begin
                rsp_d.interface_reset = 1'b1; st_d = StLoop;
              end else if ((st_q == StWaiting && (req_i.payload.event_code == EvBackup ||
                            req_i.payload.event_code == EvWait)) ||
                           (st_q >= StDrOther && req_i.payload.event_code == EvNbChg)) begin
                cdr_d = dr_q; cbdr_d = bdr_q;
                ebdr_d = '0; bpri_d = '0; hi_d = '0; hpri_d = '0; bfound_d = 1'b0;
                fsm_d = SElA;
              end else if (req_i.payload.event_code == EvHello) begin
                rsp_d.start_hello_timer = 1'b1;
                if (st_q == StP2p) begin
                  if (itype_q == TypeVirt) begin
                    scan_d = ScHello; fsm_d = SScan;
                  end else rsp_d.hello_multicast = 1'b1;
                end else if (itype_q == TypeBcast) rsp_d.hello_multicast = 1'b1;
                else begin
                  scan_d = ScAct; fsm_d = SScan;
                end
              end
            end
          end
          if (rsp_d.interface_reset) begin
            dr_d = '0; bdr_d = '0;
          end
        end
      end

      SScan: begin
        ram_raddr = AW'(cnt_q);
        if (ent_v) begin
          unique case (scan_q)
            ScUp: if (ent.pri != 8'd0) uc_d = uc_q | bit_m;
            ScHello: if (!ufound_q) begin
              uc_d = bit_m; ufound_d = 1'b1;
            end
            default: begin
              if (req_q.event_code == EvHello && st_q == StDrOther && rpri_q == 8'd0) begin
                if (dr_q == ent.id || bdr_q == ent.id) uc_d = uc_q | bit_m;
              end else if (ent.pri != 8'd0) uc_d = uc_q | bit_m;
            end
          endcase
        end
        if (cnt_q == CW'(MAX_NEIGHBORS)) begin
          if (scan_q == ScUp) rsp_d.neighbor_start_mask = uc_d;
          else rsp_d.hello_unicast_mask = uc_d;
          fsm_d = SResp;
        end else cnt_d = cnt_q + CW'(1);
      end

      SElA: begin
        if (ent_elig && ent.dr != ent.id) begin
          if (ent.bdr == ent.id && beats(ent.pri, ent.id, bpri_q, ebdr_q)) begin
            ebdr_d = ent.id; bpri_d = ent.pri; bfound_d = 1'b1;
          end
          if (beats(ent.pri, ent.id, hpri_q, hi_q)) begin
            hi_d = ent.id; hpri_d = ent.pri;
          end
        end
        if (cnt_q == CW'(MAX_NEIGHBORS)) begin
          bdr_t = ebdr_d; bpri_t = bpri_d; bfound_t = bfound_d;
          if (rpri_q != 8'd0 && cdr_q != rid_q) begin
            if (cbdr_q == rid_q && beats(rpri_q, rid_q, bpri_t, bdr_t)) begin
              bdr_t = rid_q; bpri_t = rpri_q; bfound_t = 1'b1;
            end
            if (!bfound_t) begin
              if (beats(rpri_q, rid_q, hpri_d, hi_d)) bdr_t = rid_q;
              else bdr_t = hi_d;
              bfound_t = 1'b1;
            end
          end
          if (!bfound_t) bdr_t = hi_d;
          ebdr_d = bdr_t;
          edr_d = '0; dpri_d = '0; dfound_d = 1'b0;
          cnt_d = '0; fsm_d = SElB;
        end else cnt_d = cnt_q + CW'(1);
      end

      SElB: begin
        if (ent_elig && ent.dr == ent.id && beats(ent.pri, ent.id, dpri_q, edr_q)) begin
          edr_d = ent.id; dpri_d = ent.pri; dfound_d = 1'b1;
        end
        if (cnt_q == CW'(MAX_NEIGHBORS)) begin
          fdr = edr_d;
          if (rpri_q != 8'd0 && cdr_q == rid_q && beats(rpri_q, rid_q, dpri_d, fdr)) begin
            fdr = rid_q; dfound_d = 1'b1;
          end
          if (!dfound_d) fdr = ebdr_q;
          fbdr = ebdr_q;
          el_changed = (fdr != 32'd0 && ((cdr_q == rid_q) != (fdr == rid_q))) ||
                       (fbdr != 32'd0 && ((cbdr_q == rid_q) != (fbdr == rid_q)));
          if (el_changed && !round_q) begin
            cdr_d = fdr; cbdr_d = fbdr; round_d = 1'b1;
            ebdr_d = '0; bpri_d = '0; hi_d = '0; hpri_d = '0; bfound_d = 1'b0;
            cnt_d = '0; fsm_d = SElA;
          end else begin
            was_b = (bdr_q == rid_q); was_d = (dr_q == rid_q);
            was_o = (st_q == StDrOther); was_w = !was_b && !was_d && !was_o;
            is_b = (fbdr == rid_q); is_d = (fdr == rid_q); is_o = !is_b && !is_d;
            drchg = (fdr != dr_q) || (fbdr != bdr_q);
            if (was_b) begin if (is_d) st_d = StDr; if (is_o) st_d = StDrOther; end
            if (was_d) begin if (is_b) st_d = StBackup; if (is_o) st_d = StDrOther; end
            if (was_o) begin if (is_d) st_d = StDr; if (is_b) st_d = StBackup; end
            if (was_w) begin
              if (is_d) st_d = StDr;
              if (is_b) st_d = StBackup;
              if (is_o) st_d = StDrOther;
            end
            cdr_d = fdr; cbdr_d = fbdr;
            round_d = drchg;
            sm_d = {15'd0, (itype_q == TypeNbma) && ((!was_b && is_b) || (!was_d && is_d))};
            uc_d = '0; am_d = '0;
            cnt_d = '0; fsm_d = SMask;
          end
        end else cnt_d = cnt_q + CW'(1);
      end

      SMask: begin
        if (ent_v) begin
          if (sm_q[0] && ent.pri == 8'd0) uc_d = uc_q | bit_m;
          if (round_q && ent.twoway) am_d = am_q | bit_m;
        end
        if (cnt_q == CW'(MAX_NEIGHBORS)) begin
          rsp_d.neighbor_start_mask = uc_d;
          rsp_d.adjacency_check_mask = am_d;
          dr_d = cdr_q; bdr_d = cbdr_q;
          fsm_d = SResp;
        end else cnt_d = cnt_q + CW'(1);
      end

      SResp: begin
        if (!rsp_vld_q) begin
          rsp_d.iface_state = st_q;
          rsp_d.designated_router = dr_q;
          rsp_d.backup_router = bdr_q;
          rsp_vld_d = 1'b1;
          fsm_d = SIdle;
        end
      end

      default: fsm_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= SIdle; scan_q <= ScUp; cnt_q <= '0; round_q <= 1'b0;
      st_q <= StDown; dr_q <= '0; bdr_q <= '0; valid_q <= '0;
      rsp_vld_q <= 1'b0; hi_q <= '0;
    end else begin
      fsm_q <= fsm_d; scan_q <= scan_d; cnt_q <= cnt_d; round_q <= round_d;
      st_q <= st_d; dr_q <= dr_d; bdr_q <= bdr_d; valid_q <= valid_d;
      rsp_vld_q <= rsp_vld_d; hi_q <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; rsp_q <= rsp_d;
    cdr_q <= cdr_d; cbdr_q <= cbdr_d; ebdr_q <= ebdr_d; edr_q <= edr_d;
    bpri_q <= bpri_d; hpri_q <= hpri_d; dpri_q <= dpri_d;
    bfound_q <= bfound_d; dfound_q <= dfound_d; ufound_q <= ufound_d;
    uc_q <= uc_d; sm_q <= sm_d; am_q <= am_d;
  end
endmodule
`default_nettype wire
